### design/rect_placement_occupancy_check_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle placement occupancy check
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef RECT_PLACEMENT_OCCUPANCY_CHECK_CORE_MACROS_SVH
`define RECT_PLACEMENT_OCCUPANCY_CHECK_CORE_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define RPOC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rpoc assertion failed");

// Next-cycle implication, checked only outside reset.
`define RPOC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rpoc assertion failed");

`endif

### design/rpoc_pkg.sv
// ----------------------------------------------------------------------------
// rpoc_pkg
// Types and constants shared by the rectangle placement occupancy check.
// ----------------------------------------------------------------------------
`default_nettype none

package rpoc_pkg;

  localparam int MaxWidth   = 64;
  localparam int MaxHeight  = 64;
  localparam int RowIdxW    = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int RowCntW    = $clog2(MaxHeight + 1);
  localparam int GridW      = 7;
  localparam int CoordW     = 8;
  localparam int SizeW      = 7;
  localparam int CfgIdxW    = 1;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgGridWidth  = 1'b0,
    CfgGridHeight = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KindNop,
    KindFail,
    KindPlace
  } rect_kind_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkCheck,
    BkWrite
  } back_state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] rect_x;
    logic signed [CoordW-1:0] rect_y;
    logic [SizeW-1:0]         rect_w;
    logic [SizeW-1:0]         rect_h;
    logic                     last_of_set;
  } rpoc_rect_t;

  typedef struct packed {
    logic set_valid_so_far;
    logic end_of_set;
  } rpoc_result_t;

  typedef struct packed {
    rect_kind_e            kind;
    logic [RowIdxW-1:0]    row_first;
    logic [RowCntW-1:0]    row_cnt;
    logic [MaxWidth-1:0]   col_mask;
    logic                  last;
  } rpoc_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } rpoc_qstat_t;

endpackage

`default_nettype wire

### design/rpoc_front.sv
// ----------------------------------------------------------------------------
// rpoc_front
// Holds the grid registers, accepts rectangles and classifies each one.
// ----------------------------------------------------------------------------
`default_nettype none

module rpoc_front import rpoc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               full_i,
  input  wire rpoc_rect_t         rect_i,
  input  wire logic               cfg_valid_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [GridW-1:0]   cfg_data_i,
  output logic                    push_o,
  output rpoc_entry_t             entry_o
);

  logic [GridW-1:0] grid_width_q, grid_width_d;
  logic [GridW-1:0] grid_height_q, grid_height_d;
  logic [8:0]       gw, gh, x_end, y_end, x_lo, y_lo;
  logic             zero_area, out_of_bounds;

  always_comb begin
    grid_width_d  = grid_width_q;
    grid_height_d = grid_height_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgGridWidth:  grid_width_d  = cfg_data_i;
        CfgGridHeight: grid_height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GridW'(64);
      grid_height_q <= GridW'(64);
    end else begin
      grid_width_q  <= grid_width_d;
      grid_height_q <= grid_height_d;
    end
  end

  // Oversized grids are clamped to the bitmap size.
  always_comb begin
    gw = (9'(grid_width_q) > 9'(MaxWidth)) ? 9'(MaxWidth) : 9'(grid_width_q);
    gh = (9'(grid_height_q) > 9'(MaxHeight)) ? 9'(MaxHeight) : 9'(grid_height_q);
    x_lo  = 9'(rect_i.rect_x[CoordW-2:0]);
    y_lo  = 9'(rect_i.rect_y[CoordW-2:0]);
    x_end = x_lo + 9'(rect_i.rect_w);
    y_end = y_lo + 9'(rect_i.rect_h);
    zero_area     = (rect_i.rect_w == '0) || (rect_i.rect_h == '0);
    out_of_bounds = rect_i.rect_x[CoordW-1] || rect_i.rect_y[CoordW-1] ||
                    (x_end > gw) || (y_end > gh);
  end

  always_comb begin
    push_o            = start_i && !full_i;
    entry_o.last      = rect_i.last_of_set;
    entry_o.row_first = RowIdxW'(y_lo);
    entry_o.row_cnt   = RowCntW'(rect_i.rect_h);
    for (int c = 0; c < MaxWidth; c++) begin
      entry_o.col_mask[c] = (9'(c) >= x_lo) && (9'(c) < x_end);
    end
    if (zero_area) begin
      entry_o.kind = KindNop;
    end else if (out_of_bounds) begin
      entry_o.kind = KindFail;
    end else begin
      entry_o.kind = KindPlace;
    end
  end

endmodule

`default_nettype wire

### design/rpoc_queue.sv
// ----------------------------------------------------------------------------
// rpoc_queue
// Short FIFO of classified rectangles between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rpoc_queue import rpoc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire rpoc_entry_t entry_i,
  input  wire logic        pop_i,
  output rpoc_entry_t      entry_o,
  output rpoc_qstat_t      stat_o
);

  rpoc_entry_t       slot_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q;
  logic              do_push, do_pop;

  always_comb begin
    stat_o.empty = (count_q == '0);
    stat_o.full  = (count_q == QCntW'(QueueDepth));
    do_push      = push_i && !stat_o.full;
    do_pop       = pop_i && !stat_o.empty;
    entry_o      = slot_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCntW'(do_push) - QCntW'(do_pop);
    end
  end

endmodule

`default_nettype wire

### design/rpoc_back.sv
// ----------------------------------------------------------------------------
// rpoc_back
// Owns the row bitmap: checks each placeable rectangle row by row, then marks it if no cell is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rpoc_back import rpoc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire rpoc_qstat_t qstat_i,
  input  wire rpoc_entry_t entry_i,
  output logic             pop_o,
  output logic             done_o,
  output rpoc_result_t     result_o
);

  back_state_e         state_q, state_d;
  logic [RowIdxW-1:0]  row_q, row_d, first_q, first_d, pend_row_q, pend_row_d;
  logic [RowCntW-1:0]  left_q, left_d, cnt_q, cnt_d;
  logic [MaxWidth-1:0] mask_q, mask_d;
  logic                last_q, last_d, hit_q, hit_d, pend_q, pend_d;
  logic                flag_q, flag_d, done_q, done_d;
  rpoc_result_t        res_q, res_d;

  // Bitmap memory; a row whose valid bit is low reads as empty.
  logic [MaxWidth-1:0]  mem_q [MaxHeight];
  logic [MaxHeight-1:0] row_vld_q;
  logic [MaxWidth-1:0]  rd_data_q, row_eff, wr_data;
  logic                 rd_vld_bit_q;
  logic                 rd_en, wr_en, finish, ok, fin_last, flag_new;
  logic [RowIdxW-1:0]   rd_addr;

  assign row_eff = rd_vld_bit_q ? rd_data_q : '0;

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    first_d    = first_q;
    left_d     = left_q;
    cnt_d      = cnt_q;
    mask_d     = mask_q;
    last_d     = last_q;
    hit_d      = hit_q;
    pend_d     = 1'b0;
    pend_row_d = row_q;
    pop_o      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = row_q;
    wr_en      = 1'b0;
    wr_data    = row_eff | mask_q;
    finish     = 1'b0;
    ok         = 1'b0;
    fin_last   = last_q;
    case (state_q)
      BkIdle: begin
        if (!qstat_i.empty) begin
          pop_o   = 1'b1;
          row_d   = entry_i.row_first;
          first_d = entry_i.row_first;
          left_d  = entry_i.row_cnt;
          cnt_d   = entry_i.row_cnt;
          mask_d  = entry_i.col_mask;
          last_d  = entry_i.last;
          hit_d   = 1'b0;
          case (entry_i.kind)
            KindPlace: state_d = BkCheck;
            KindFail: begin
              finish   = 1'b1;
              fin_last = entry_i.last;
            end
            default: begin
              finish   = 1'b1;
              ok       = 1'b1;
              fin_last = entry_i.last;
            end
          endcase
        end
      end
      BkCheck: begin
        if (left_q != '0) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          row_d  = row_q + 1'b1;
          left_d = left_q - 1'b1;
        end
        if (pend_q && ((row_eff & mask_q) != '0)) begin
          hit_d = 1'b1;
        end
        if ((left_q == '0) && !pend_q) begin
          if (hit_q) begin
            finish  = 1'b1;
            state_d = BkIdle;
          end else begin
            state_d = BkWrite;
            row_d   = first_q;
            left_d  = cnt_q;
          end
        end
      end
      BkWrite: begin
        if (left_q != '0) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          row_d  = row_q + 1'b1;
          left_d = left_q - 1'b1;
        end
        wr_en = pend_q;
        if ((left_q == '0) && !pend_q) begin
          finish  = 1'b1;
          ok      = 1'b1;
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase

    flag_new                 = flag_q && ok;
    done_d                   = finish;
    res_d.set_valid_so_far   = flag_new;
    res_d.end_of_set         = fin_last;
    flag_d                   = flag_q;
    if (finish) begin
      flag_d = fin_last ? 1'b1 : flag_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      left_q  <= '0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
      flag_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
      hit_q   <= hit_d;
      flag_q  <= flag_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    first_q    <= first_d;
    cnt_q      <= cnt_d;
    mask_q     <= mask_d;
    last_q     <= last_d;
    pend_row_q <= pend_row_d;
    res_q      <= res_d;
  end

  // Valid bits: cleared together at reset and at the end of a set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (finish && fin_last) begin
      row_vld_q <= '0;
    end else if (wr_en) begin
      row_vld_q[pend_row_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[pend_row_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q    <= mem_q[rd_addr];
      rd_vld_bit_q <= row_vld_q[rd_addr];
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

### design/rect_placement_occupancy_check_core.sv
// ----------------------------------------------------------------------------
// Rectangle placement occupancy check
// Checks rectangles against a grid and an occupancy bitmap, one verdict each.
// ----------------------------------------------------------------------------
// Usage: a rectangle beat is taken at a rising edge where start is high and
// busy is low. busy rises only when the two-entry queue between the front
// and the back is full, so the front keeps taking beats while the back works.
// Each rectangle yields exactly one result beat: done_o is high for one
// cycle with result_o valid, and it must be captured in that cycle, since the
// receiver has no way to stall the block.
// Flow: a zero-area or out-of-bounds rectangle taken while the back is
// idle passes through the queue and the result register. A free rectangle that
// is in bounds makes two passes in the back: one pass reads and checks
// its h row words, one word per cycle, and a second pass reads them again
// and writes the marked words back, each write in the cycle after its read.
// If the check pass finds an occupied cell, the back finishes without the
// write pass. The verdict goes out through the result register. Throughput
// is set by the bitmap, one row word per cycle.
// The configuration channel (cfg_valid_i, cfg_ready_o, cfg_index_i,
// cfg_data_i) is always ready; index 0 is the grid width, index 1 the height.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_placement_occupancy_check_core import rpoc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire rpoc_rect_t         rect_i,
  output logic                    done_o,
  output rpoc_result_t            result_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [GridW-1:0]   cfg_data_i
);

  // Reset clears the bitmap valid bits, sets the verdict flag and loads a
  // 64 by 64 grid; the end of a set clears the valid bits and sets the flag again.

  // Classified rectangles travel from the front to the back through the queue.
  rpoc_entry_t front_entry, queue_entry;
  rpoc_qstat_t qstat;
  logic        push, pop;

  // Writes go straight into the grid registers, so the channel never pushes back.
  assign cfg_ready_o = 1'b1;

  // busy reflects only the queue: the back may be mid-rectangle while the
  // front still accepts the next beat.
  assign busy = qstat.full;

  rpoc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .full_i      (qstat.full),
    .rect_i      (rect_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .entry_o     (front_entry)
  );

  rpoc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .entry_o (queue_entry),
    .stat_o  (qstat)
  );

  // The back holds the bitmap and the sticky verdict flag, and drives the
  // registered result beat.
  rpoc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .qstat_i  (qstat),
    .entry_i  (queue_entry),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

### design/rpoc_checker.sv
// ----------------------------------------------------------------------------
// rpoc_checker
// Port-level checks of beat bookkeeping and the sticky verdict.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rect_placement_occupancy_check_core_macros.svh"

module rpoc_checker import rpoc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic         busy_i,
  input  wire logic         done_i,
  input  wire rpoc_result_t result_i
);

  logic [2:0] outstanding_q;
  logic       fail_seen_q;
  logic       accept;

  assign accept = start_i && !busy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
      fail_seen_q   <= 1'b0;
    end else begin
      outstanding_q <= outstanding_q + 3'(accept) - 3'(done_i);
      if (done_i && result_i.end_of_set) begin
        fail_seen_q <= 1'b0;
      end else if (done_i && !result_i.set_valid_so_far) begin
        fail_seen_q <= 1'b1;
      end
    end
  end

  `RPOC_ASSERT_IMPLIES(a_done_has_beat, clk_i, rst_ni, done_i, outstanding_q != 3'd0)
  `RPOC_ASSERT_IMPLIES(a_busy_means_backlog, clk_i, rst_ni, busy_i, outstanding_q >= 3'd2)
  `RPOC_ASSERT_IMPLIES(a_accept_bounded, clk_i, rst_ni, accept, outstanding_q <= 3'd2)
  `RPOC_ASSERT_IMPLIES(a_verdict_sticky, clk_i, rst_ni, done_i && fail_seen_q, !result_i.set_valid_so_far)

endmodule

bind rect_placement_occupancy_check_core rpoc_checker u_rpoc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start),
  .busy_i   (busy),
  .done_i   (done_o),
  .result_i (result_o)
);

`default_nettype wire
